// ===== hw/rtl/wsdf_pkg.sv =====
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsdf_pkg;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// Frame status codes.
	localparam logic [2:0] ST_TEXT      = 3'd0;
	localparam logic [2:0] ST_CLOSE     = 3'd1;
	localparam logic [2:0] ST_PING      = 3'd2;
	localparam logic [2:0] ST_PONG      = 3'd3;
	localparam logic [2:0] ST_OTHER     = 3'd4;
	localparam logic [2:0] ST_TOO_LARGE = 3'd5;

	// Opcodes of interest.
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	// 7-bit length codes that announce an extended length field.
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	// Byte counts of the extended length and key fields.
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	// Limit register.
	localparam int unsigned LIMIT_W = 25;
	localparam logic [LIMIT_W-1:0] LIMIT_CAP       = 25'd16777216;
	localparam logic [LIMIT_W-1:0] MAX_PAYLOAD_RST = 25'd65536;

	// One result item.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        data_valid;
		logic        frame_end;
		logic [2:0]  frame_status;
		logic [23:0] frame_length;
	} res_t;

	function automatic logic [2:0] status_of(input logic over, input logic [3:0] opcode);
		logic [2:0] st;
		if (over) begin
			st = ST_TOO_LARGE;
		end else begin
			case (opcode)
				OP_TEXT:  st = ST_TEXT;
				OP_CLOSE: st = ST_CLOSE;
				OP_PING:  st = ST_PING;
				OP_PONG:  st = ST_PONG;
				default:  st = ST_OTHER;
			endcase
		end
		return st;
	endfunction

endpackage

// ===== hw/rtl/wsdf_parser.sv =====
// Frame header parser, unmasker and frame state for the deframer.
module wsdf_parser import wsdf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte_s1,
	input  logic [LIMIT_W-1:0] max_payload,
	output logic               res_vld,
	output res_t               res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [63:0] len_q, len_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  idx_q, idx_d;
	logic        over_q, over_d;

	logic [6:0]         len7;
	logic               is_ext;
	logic [63:0]        ext_len;
	logic [63:0]        hdr_len;
	logic [3:0]         cnt_dec;
	logic               field_last;
	logic               mask_now;
	logic               len_done;
	logic [LIMIT_W-1:0] lim;
	logic               over_cand;
	logic               last;
	logic [7:0]         plain;
	phase_t             after_len_phase;
	phase_t             after_key_phase;

	assign len7       = rx_byte_s1[6:0];
	assign is_ext     = (len7 == LEN_CODE_16) || (len7 == LEN_CODE_64);
	assign ext_len    = {len_q[55:0], rx_byte_s1};
	assign hdr_len    = (phase_q == PH_HDR1) ? {57'd0, len7} : ext_len;
	assign cnt_dec    = cnt_q - 4'd1;
	assign field_last = (cnt_dec == 4'd0);
	assign mask_now   = (phase_q == PH_HDR1) ? rx_byte_s1[7] : masked_q;
	assign len_done   = ((phase_q == PH_HDR1) && !is_ext) ||
	                    ((phase_q == PH_EXTLEN) && field_last);
	assign lim        = (max_payload > LIMIT_CAP) ? LIMIT_CAP : max_payload;
	assign over_cand  = (|hdr_len[63:LIMIT_W]) || (hdr_len[LIMIT_W-1:0] >= lim);
	assign last       = (rem_q == 64'd1);
	assign plain      = rx_byte_s1 ^ key_q[{~idx_q, 3'b000} +: 8];

	assign after_len_phase = mask_now ? PH_KEY : ((hdr_len == 64'd0) ? PH_HDR0 : PH_PAYLOAD);
	assign after_key_phase = (len_q == 64'd0) ? PH_HDR0 : PH_PAYLOAD;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			case (phase_q)
				PH_HDR1:    phase_d = is_ext ? PH_EXTLEN : after_len_phase;
				PH_EXTLEN:  phase_d = field_last ? after_len_phase : PH_EXTLEN;
				PH_KEY:     phase_d = field_last ? after_key_phase : PH_KEY;
				PH_PAYLOAD: phase_d = last ? PH_HDR0 : PH_PAYLOAD;
				default:    phase_d = PH_HDR1;
			endcase
		end
	end

	// Frame fields and result.
	always_comb begin
		opcode_d = opcode_q;
		masked_d = masked_q;
		cnt_d    = cnt_q;
		len_d    = len_q;
		rem_d    = rem_q;
		key_d    = key_q;
		idx_d    = idx_q;
		over_d   = over_q;
		res_vld  = 1'b0;
		res      = '0;
		if (step) begin
			case (phase_q)
				PH_HDR1: begin
					masked_d = rx_byte_s1[7];
					if (is_ext) begin
						len_d = 64'd0;
						cnt_d = (len7 == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
					end else begin
						len_d = hdr_len;
					end
				end
				PH_EXTLEN: begin
					len_d = ext_len;
					cnt_d = cnt_dec;
				end
				PH_KEY: begin
					key_d = {key_q[23:0], rx_byte_s1};
					cnt_d = cnt_dec;
					if (field_last) begin
						if (len_q == 64'd0) begin
							res_vld          = 1'b1;
							res.frame_end    = 1'b1;
							res.frame_status = status_of(over_q, opcode_q);
						end else begin
							rem_d = len_q;
							idx_d = 2'd0;
						end
					end
				end
				PH_PAYLOAD: begin
					idx_d = idx_q + 2'd1;
					rem_d = rem_q - 64'd1;
					if (over_q) begin
						if (last) begin
							res_vld          = 1'b1;
							res.frame_end    = 1'b1;
							res.frame_status = ST_TOO_LARGE;
						end
					end else begin
						res_vld        = 1'b1;
						res.data_byte  = plain;
						res.data_valid = 1'b1;
						if (last) begin
							res.frame_end    = 1'b1;
							res.frame_status = status_of(1'b0, opcode_q);
							res.frame_length = len_q[23:0];
						end
					end
				end
				default: begin
					opcode_d = rx_byte_s1[3:0];
					masked_d = 1'b0;
					cnt_d    = 4'd0;
					len_d    = 64'd0;
					key_d    = 32'd0;
					idx_d    = 2'd0;
					over_d   = 1'b0;
				end
			endcase

			// Length complete: check the limit, then go to the key or the payload, or finish.
			if (len_done) begin
				over_d = over_cand;
				key_d  = 32'd0;
				if (mask_now) begin
					cnt_d = KEY_BYTES;
				end else if (hdr_len == 64'd0) begin
					res_vld          = 1'b1;
					res.frame_end    = 1'b1;
					res.frame_status = status_of(over_cand, opcode_q);
				end else begin
					rem_d = hdr_len;
					idx_d = 2'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			cnt_q    <= 4'd0;
			len_q    <= 64'd0;
			rem_q    <= 64'd0;
			key_q    <= 32'd0;
			idx_q    <= 2'd0;
			over_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			cnt_q    <= cnt_d;
			len_q    <= len_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
			over_q   <= over_d;
		end
	end

endmodule

// ===== hw/rtl/wsdf_out_reg.sv =====
// Result register of the deframer, held until the receiver takes it.
module wsdf_out_reg import wsdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic ready,
	output logic valid,
	output res_t res_out
);

	logic vld_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign valid   = vld_q;
	assign res_out = res_q;

endmodule

// ===== hw/rtl/websocket_frame_deframer_core.sv =====
// Top level of the WebSocket frame deframer: input register, parser and result register.
//
// Usage: received bytes enter on rx_byte with in_valid/in_ready, one item a byte.
// Each byte yields zero or one result item on the output channel
// (out_valid/out_ready): an unmasked payload byte (data_valid), a frame end
// with status and length (frame_end), or both on the last payload byte.
// Header bytes, extended length bytes, mask key bytes and the bytes of a
// too large frame yield no result, except the byte that ends a frame.
// max_payload is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// Path: an accepted byte waits in the input register, is parsed once the result slot
// is free or draining, and its result is registered in the result register.
// Throughput: one byte per cycle while the result slot is free or draining; the parser
// updates its frame state per parsed byte, so such bytes never wait on each other.
// Stalls: when out_ready is low with a result pending, the block holds the byte in its
// input register and in_ready drops only once that register is also full; nothing is
// lost or repeated.
// Reset: arst_n clears the parser to await a frame's first header byte,
// empties both registers and sets max_payload to 65536.
module websocket_frame_deframer_core import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [24:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic        frame_end,
	output logic [2:0]  frame_status,
	output logic [23:0] frame_length
);

	logic [LIMIT_W-1:0] max_payload_q;
	logic               vld_s1;
	logic [7:0]         byte_s1;
	logic               advance;
	logic               res_vld;
	res_t               res;
	res_t               res_out;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// Parse the held byte once the result slot is free or draining; this
	// also covers bytes that produce no result.
	assign advance  = vld_s1 && (!out_valid || out_ready);
	assign in_ready = !vld_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	wsdf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte_s1 (byte_s1),
		.max_payload(max_payload_q),
		.res_vld    (res_vld),
		.res        (res)
	);

	wsdf_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_vld),
		.res_in (res),
		.ready  (out_ready),
		.valid  (out_valid),
		.res_out(res_out)
	);

	assign data_byte    = res_out.data_byte;
	assign data_valid   = res_out.data_valid;
	assign frame_end    = res_out.frame_end;
	assign frame_status = res_out.frame_status;
	assign frame_length = res_out.frame_length;

	// A result that does not close a frame is always a payload byte.
	a_mid_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> data_valid && (frame_status == ST_TEXT) &&
		(frame_length == 24'd0))
		else $error("non-final result without payload byte");

	// No payload byte means a zero byte field and a frame end.
	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> (data_byte == 8'd0) && frame_end)
		else $error("empty result carries data");

	// A too large frame reports no length and no byte.
	a_too_large: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (frame_status == ST_TOO_LARGE) |->
		(frame_length == 24'd0) && !data_valid)
		else $error("too large frame carries payload");

	// A held byte stays held while the result slot is blocked.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(byte_s1))
		else $error("input register lost a byte");

endmodule

// ===== tb/sv/tb_websocket_frame_deframer_core.sv =====
// Self-checking testbench for the WebSocket frame deframer core.
module tb_websocket_frame_deframer_core;
	import wsdf_pkg::*;

	// Run limits and idling levels.
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_TAIL   = 8;
	localparam int HOLDOFF_LEN  = 200;
	localparam int IDLE_NONE    = 0;
	localparam int IDLE_HEAVY   = 86;
	localparam int IDLE_BOTH    = 36;
	localparam int SHOWN_ERRORS = 10;

	// Predicts the deframed output stream and checks the block against it.
	class deframe_scoreboard;
		phase_t            ph;
		logic [3:0]        opcode;
		logic              masked;
		logic [3:0]        field_left;
		logic [63:0]       plen;
		logic [31:0]       key;
		logic [63:0]       pidx;
		logic              over;
		logic [LIMIT_W-1:0] limit;
		res_t              staged;
		bit                staged_ok;
		res_t              pending_out[$];
		int                errors;
		int                bytes_in;
		int                payload_out;
		int                frames_out;
		int                dropped_frames;

		function new();
			ph = PH_HDR0;
			opcode = '0;
			masked = 1'b0;
			field_left = '0;
			plen = '0;
			key = '0;
			pidx = '0;
			over = 1'b0;
			limit = MAX_PAYLOAD_RST;
			errors = 0;
			bytes_in = 0;
			payload_out = 0;
			frames_out = 0;
			dropped_frames = 0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return pending_out.size();
		endfunction

		function logic [2:0] frame_code();
			if (over)
				return ST_TOO_LARGE;
			case (opcode)
				OP_TEXT:  return ST_TEXT;
				OP_CLOSE: return ST_CLOSE;
				OP_PING:  return ST_PING;
				OP_PONG:  return ST_PONG;
				default:  return ST_OTHER;
			endcase
		endfunction

		// Close an empty frame right away, or move on to the payload.
		function void header_known();
			if (plen == 64'd0) begin
				ph = PH_HDR0;
				staged = '0;
				staged.frame_end = 1'b1;
				staged.frame_status = frame_code();
				staged_ok = 1'b1;
			end else begin
				ph = PH_PAYLOAD;
				pidx = '0;
			end
		endfunction

		// Judge the length against the clamped limit, then read the key, close an empty frame or move on to the payload.
		function void length_known();
			logic [LIMIT_W-1:0] lim;
			lim = (limit > LIMIT_CAP) ? LIMIT_CAP : limit;
			over = (plen >= 64'(lim));
			key = '0;
			if (masked) begin
				ph = PH_KEY;
				field_left = KEY_BYTES;
			end else begin
				header_known();
			end
		endfunction

		// Advance the parser by one accepted byte and queue its result, if any.
		function void take_rx_byte(logic [7:0] b);
			logic [7:0] plain;
			int         ks;
			bit         last_one;
			staged_ok = 1'b0;
			staged = '0;
			bytes_in++;
			case (ph)
				PH_HDR1: begin
					masked = b[7];
					if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64) begin
						plen = '0;
						field_left = (b[6:0] == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
						ph = PH_EXTLEN;
					end else begin
						plen = 64'(b[6:0]);
						length_known();
					end
				end
				PH_EXTLEN: begin
					plen = {plen[55:0], b};
					if (field_left != 0)
						field_left--;
					if (field_left == 0)
						length_known();
				end
				PH_KEY: begin
					key = {key[23:0], b};
					if (field_left != 0)
						field_left--;
					if (field_left == 0)
						header_known();
				end
				PH_PAYLOAD: begin
					ks = 31 - 8 * int'(pidx[1:0]);
					plain = b ^ key[ks -: 8];
					pidx++;
					last_one = (pidx >= plen);
					if (last_one)
						ph = PH_HDR0;
					if (over) begin
						if (last_one) begin
							staged.frame_end = 1'b1;
							staged.frame_status = ST_TOO_LARGE;
							staged_ok = 1'b1;
						end
					end else begin
						staged.data_byte = plain;
						staged.data_valid = 1'b1;
						if (last_one) begin
							staged.frame_end = 1'b1;
							staged.frame_status = frame_code();
							staged.frame_length = plen[23:0];
						end
						staged_ok = 1'b1;
					end
				end
				default: begin
					opcode = b[3:0];
					masked = 1'b0;
					field_left = '0;
					plen = '0;
					key = '0;
					pidx = '0;
					over = 1'b0;
					ph = PH_HDR1;
				end
			endcase
			if (staged_ok)
				pending_out.push_back(staged);
		endfunction

		function void report(string what, res_t want, res_t got);
			errors++;
			if (errors <= SHOWN_ERRORS) begin
				$display("MISMATCH (%s): expected byte %02h dv %0d end %0d st %0d len %0d,",
					what, want.data_byte, want.data_valid, want.frame_end,
					want.frame_status, want.frame_length);
				$display("    got byte %02h dv %0d end %0d st %0d len %0d",
					got.data_byte, got.data_valid, got.frame_end,
					got.frame_status, got.frame_length);
			end
		endfunction

		// Compare one accepted result with the oldest prediction.
		function void check_output(res_t got);
			res_t want;
			bit   bad;
			if (pending_out.size() == 0) begin
				report("no result due", '0, got);
				return;
			end
			want = pending_out.pop_front();
			bad = 1'b0;
			if (got.data_byte !== want.data_byte)
				bad = 1'b1;
			if (got.data_valid !== want.data_valid)
				bad = 1'b1;
			if (got.frame_end !== want.frame_end)
				bad = 1'b1;
			if (got.frame_status !== want.frame_status)
				bad = 1'b1;
			if (got.frame_length !== want.frame_length)
				bad = 1'b1;
			if (bad)
				report("field", want, got);
			if (want.data_valid)
				payload_out++;
			if (want.frame_end)
				frames_out++;
			if (want.frame_end && want.frame_status == ST_TOO_LARGE)
				dropped_frames++;
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [24:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         data_byte;
	logic               data_valid;
	logic               frame_end;
	logic [2:0]         frame_status;
	logic [23:0]        frame_length;

	deframe_scoreboard  sb;
	int                 cycle_count;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	bit                 holdoff_req;
	int                 bytes_sent;
	int                 limit_settings;
	logic [LIMIT_W-1:0] cur_limit;

	websocket_frame_deframer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.data_valid   (data_valid),
		.frame_end    (frame_end),
		.frame_status (frame_status),
		.frame_length (frame_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if it hangs.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due",
				cycle_count, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Sample both handshakes at the rising edge; note the input first so that
	// its prediction is queued before any result can be compared.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_rx_byte(rx_byte);
			if (out_valid && out_ready)
				sb.check_output({data_byte, data_valid, frame_end, frame_status, frame_length});
		end
	end

	// Receiver: stall at random per the current level, or hold off for a long
	// stretch on request so the block backs up into its input.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				hold_left = HOLDOFF_LEN;
				holdoff_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offer one byte after a random gap and hold it until accepted.
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// Drop valid after the last byte of a burst.
	task automatic sender_rest();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Hold the sender until every predicted result has come out.
	task automatic wait_results();
		sender_rest();
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	// Drain, then let header bytes still in flight settle before touching config.
	task automatic wait_idle();
		wait_results();
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_limit(v);
		cur_limit = v;
		limit_settings++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Send one frame: header, extended length (big-endian) if the code asks,
	// key if masked, then random payload bytes.
	task automatic emit_frame(input logic [7:0] hdr0, input bit masked,
			input int unsigned len, input logic [6:0] code, input logic [31:0] key);
		logic [63:0] len64;
		len64 = 64'(len);
		send_byte(hdr0);
		send_byte({masked, code});
		if (code == LEN_CODE_16) begin
			send_byte(len64[15:8]);
			send_byte(len64[7:0]);
		end else if (code == LEN_CODE_64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len64[8*i +: 8]);
		end
		if (masked)
			for (int i = 3; i >= 0; i--)
				send_byte(key[8*i +: 8]);
		repeat (len) send_byte(8'($urandom_range(0, 255)));
	endtask

	// Mostly well-formed frames with known opcodes; the rest carry arbitrary
	// first bytes (reserved bits, FIN clear, other opcodes). Lengths stay small,
	// hug the limit when it is small, and sometimes use a non-minimal encoding.
	task automatic send_random_frame();
		logic [7:0]  hdr0;
		logic [3:0]  op;
		logic [6:0]  code;
		logic [31:0] key;
		bit          masked;
		int unsigned len;
		int unsigned pick;
		case ($urandom_range(0, 3))
			0:       op = OP_TEXT;
			1:       op = OP_CLOSE;
			2:       op = OP_PING;
			default: op = OP_PONG;
		endcase
		if ($urandom_range(0, 99) < 80)
			hdr0 = {4'b1000, op};
		else
			hdr0 = 8'($urandom_range(0, 255));
		masked = 1'($urandom_range(0, 1));
		key = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			len = 0;
		else if (pick < 65)
			len = $urandom_range(1, 20);
		else if (pick < 80)
			len = $urandom_range(21, 125);
		else if (pick < 90 && cur_limit >= 1 && cur_limit <= 300)
			len = int'(cur_limit) - 1 + $urandom_range(0, 1);
		else
			len = $urandom_range(126, 200);
		if (len > 125)
			code = ($urandom_range(0, 2) == 0) ? LEN_CODE_64 : LEN_CODE_16;
		else if ($urandom_range(0, 99) < 15)
			code = ($urandom_range(0, 1) == 0) ? LEN_CODE_64 : LEN_CODE_16;
		else
			code = 7'(len);
		emit_frame(hdr0, masked, len, code, key);
	endtask

	// One phase: new limit and idling levels, then random frames up to a byte budget.
	task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int s_pct, input int r_pct,
			input int budget, input bit holdoff, input bit pause_mid);
		int  start;
		bit  paused;
		wait_idle();
		write_limit(lim);
		@(posedge clk);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		if (holdoff)
			holdoff_req = 1'b1;
		start = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start < budget) begin
			send_random_frame();
			if (pause_mid && !paused && bytes_sent - start > budget / 2) begin
				wait_results();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		send_idle_pct = IDLE_NONE;
		recv_stall_pct = IDLE_NONE;
		holdoff_req = 1'b0;
		bytes_sent = 0;
		limit_settings = 0;
		cur_limit = MAX_PAYLOAD_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset limit.
		// Empty unmasked text frame: frame end on the length byte.
		emit_frame({4'b1000, OP_TEXT}, 1'b0, 0, 7'd0, 32'h0);
		// Masked one-byte ping: the only byte is both payload and frame end.
		emit_frame({4'b1000, OP_PING}, 1'b1, 1, 7'd1, 32'hFFFF_FFFF);
		// Close with a non-minimal 16-bit extended length.
		emit_frame({4'b1000, OP_CLOSE}, 1'b0, 1, LEN_CODE_16, 32'h0);
		// Pong with FIN clear and reserved bits set, masked and empty:
		// frame end on the last key byte.
		emit_frame({4'b0111, OP_PONG}, 1'b1, 0, 7'd0, 32'h0000_0000);
		// Continuation opcode reports as other.
		emit_frame(8'h00, 1'b0, 0, 7'd0, 32'h0);
		// Zero limit: everything is too large, empty or not.
		wait_idle();
		write_limit(25'd0);
		emit_frame({4'b1000, OP_TEXT}, 1'b0, 0, 7'd0, 32'h0);
		emit_frame({4'b1111, OP_TEXT}, 1'b0, 2, 7'd2, 32'h0);

		// Random phases over limits from zero to above the cap. Each phase
		// overruns its budget by the tail of its last frame.
		run_phase(MAX_PAYLOAD_RST, IDLE_NONE, IDLE_NONE, 40, 1'b1, 1'b0);
		run_phase(25'd0, IDLE_HEAVY, IDLE_NONE, 10, 1'b0, 1'b1);
		run_phase(25'd1, IDLE_NONE, IDLE_HEAVY, 10, 1'b0, 1'b0);
		run_phase(LIMIT_CAP, IDLE_BOTH, IDLE_BOTH, 10, 1'b0, 1'b0);
		run_phase(25'h1FF_FFFF, IDLE_NONE, IDLE_NONE, 10, 1'b0, 1'b0);
		run_phase(25'd20, IDLE_HEAVY, IDLE_NONE, 10, 1'b0, 1'b0);
		run_phase(25'd5, IDLE_NONE, IDLE_HEAVY, 10, 1'b0, 1'b1);
		run_phase(25'd300, IDLE_BOTH, IDLE_BOTH, 10, 1'b0, 1'b0);

		// Drain and give stray results a chance to show up.
		wait_idle();
		if (sb.pending() != 0)
			sb.report("result never came", sb.pending_out[0], '0);

		$display("Run covered %0d bytes in, %0d payload bytes and %0d frame ends out",
			sb.bytes_in, sb.payload_out, sb.frames_out);
		$display("(%0d too large) over %0d limit settings; %0d mismatches",
			sb.dropped_frames, limit_settings, sb.errors);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/wsdf_pkg.sv
hw/rtl/wsdf_parser.sv
hw/rtl/wsdf_out_reg.sv
hw/rtl/websocket_frame_deframer_core.sv
tb/sv/tb_websocket_frame_deframer_core.sv
